[sv/assert_macros.svh]
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition implies a consequence on the next clock edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/psmt_pkg.sv]
package psmt_pkg;

    localparam int CFG_REG_BITS = 13;
    localparam int SYNC_BIT_POS = 3;

    localparam logic [1:0] CFG_WIDTH_IDX  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT_IDX = 2'd1;

    localparam logic [CFG_REG_BITS-1:0] WIDTH_RESET  = 13'd1024;
    localparam logic [CFG_REG_BITS-1:0] HEIGHT_RESET = 13'd768;

    // byte position within a packet
    localparam logic [1:0] IDX_STATUS = 2'd0;
    localparam logic [1:0] IDX_XDELTA = 2'd1;
    localparam logic [1:0] IDX_YDELTA = 2'd2;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_BITS = 1;
    localparam int FIFO_CNT_BITS = 2;

    localparam logic signed [10:0] OVF_EXTRA = 11'sd255;

    typedef struct packed {
        logic [7:0] y_byte;
        logic [7:0] x_byte;
        logic [7:0] status;
    } packet_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    // 9-bit signed delta plus the overflow extension in the delta's direction
    function automatic logic signed [10:0] axis_delta(input logic [7:0] delta_byte,
                                                      input logic neg, input logic ovf);
        logic signed [10:0] d;
        d = $signed({{2{neg}}, neg, delta_byte});
        if (ovf)
        begin
            d = neg ? (d - OVF_EXTRA) : (d + OVF_EXTRA);
        end
        return d;
    endfunction

endpackage

[sv/ps2_mouse_packet_tracker_top.sv]
// PS/2 mouse packet tracker. Mouse bytes enter one per cycle on s_axis; a byte
// offered as the first of a packet is dropped unless its bit 3 is set. The
// third byte of a packet closes it; packets go into a two-entry queue, and the
// back end takes one per cycle while its output register is free or being
// emptied, moves the cursor by the signed X and inverted Y deltas (overflow
// adds 255 more), clamps to the screen and holds the result in that register,
// which drives m_axis. Bytes are taken every cycle while the result side keeps
// up; the queue and the output register absorb short stalls. screen_width
// (index 0) and screen_height (index 1) reset to 1024 and 768; the user must
// write them through the cfg port only while no packet is in flight; unenforced.
module ps2_mouse_packet_tracker_top #(
    parameter int COORD_BITS = 12
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [7:0]                 s_axis_tdata,  // data_byte
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // pos_x, pos_y, left_button, right_button, middle_button, zero fill
    output logic [((2 * COORD_BITS + 3 + 7) / 8) * 8-1:0] m_axis_tdata,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [1:0]                 cfg_index,
    input  logic [psmt_pkg::CFG_REG_BITS-1:0] cfg_data
);
    import psmt_pkg::*;

    localparam int OUT_RAW  = 2 * COORD_BITS + 3;
    localparam int OUT_BITS = ((OUT_RAW + 7) / 8) * 8;
    localparam int LW = (COORD_BITS > CFG_REG_BITS) ? COORD_BITS : CFG_REG_BITS;

    // highest coordinate for a screen size, saturated to the coordinate range
    function automatic logic [COORD_BITS-1:0] size_to_lim(input logic [CFG_REG_BITS-1:0] size);
        logic [CFG_REG_BITS-1:0] m1;
        logic [LW-1:0]           m1w;
        logic [LW-1:0]           maskw;
        m1    = (size == '0) ? '0 : size - 1'b1;
        m1w   = LW'(m1);
        maskw = LW'({COORD_BITS{1'b1}});
        return (m1w > maskw) ? {COORD_BITS{1'b1}} : m1w[COORD_BITS-1:0];
    endfunction

    logic [COORD_BITS-1:0] x_lim_reg, y_lim_reg;
    logic                  push, pop;
    packet_t               push_pkt, pop_pkt;
    fifo_stat_t            fifo_stat;
    logic [COORD_BITS-1:0] pos_x, pos_y;
    logic [2:0]            buttons;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_lim_reg <= size_to_lim(WIDTH_RESET);
            y_lim_reg <= size_to_lim(HEIGHT_RESET);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_WIDTH_IDX:  x_lim_reg <= size_to_lim(cfg_data);
                CFG_HEIGHT_IDX: y_lim_reg <= size_to_lim(cfg_data);
                default:        ;
            endcase
        end
    end

    psmt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .push      (push),
        .push_pkt  (push_pkt),
        .fifo_stat (fifo_stat)
    );

    psmt_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_pkt (push_pkt),
        .pop      (pop),
        .pop_pkt  (pop_pkt),
        .stat     (fifo_stat)
    );

    psmt_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .x_lim     (x_lim_reg),
        .y_lim     (y_lim_reg),
        .fifo_stat (fifo_stat),
        .pop_pkt   (pop_pkt),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .buttons   (buttons)
    );

    assign m_axis_tdata = OUT_BITS'({buttons, pos_y, pos_x});

endmodule

[sv/psmt_front.sv]
`include "assert_macros.svh"

module psmt_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           in_byte,
    output logic                 push,
    output psmt_pkg::packet_t    push_pkt,
    input  psmt_pkg::fifo_stat_t fifo_stat
);
    import psmt_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic [7:0] status_reg, status_next;
    logic [7:0] xbyte_reg, xbyte_next;
    logic       accept;

    // only the closing byte needs queue space
    assign in_ready = !fifo_stat.full || (idx_reg != IDX_YDELTA);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        idx_next    = idx_reg;
        status_next = status_reg;
        xbyte_next  = xbyte_reg;
        push        = 1'b0;
        if (accept)
        begin
            unique case (idx_reg)
                IDX_STATUS:
                begin
                    // drop bytes without the sync bit to resynchronize
                    if (in_byte[SYNC_BIT_POS])
                    begin
                        status_next = in_byte;
                        idx_next    = IDX_XDELTA;
                    end
                end
                IDX_XDELTA:
                begin
                    xbyte_next = in_byte;
                    idx_next   = IDX_YDELTA;
                end
                IDX_YDELTA:
                begin
                    push     = 1'b1;
                    idx_next = IDX_STATUS;
                end
                default:
                begin
                    idx_next = IDX_STATUS;
                end
            endcase
        end
    end

    assign push_pkt.status = status_reg;
    assign push_pkt.x_byte = xbyte_reg;
    assign push_pkt.y_byte = in_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= IDX_STATUS;
            status_reg <= '0;
            xbyte_reg  <= '0;
        end
        else
        begin
            idx_reg    <= idx_next;
            status_reg <= status_next;
            xbyte_reg  <= xbyte_next;
        end
    end

    `ASSERT_ALWAYS(a_idx_valid, idx_reg != 2'd3, "byte index reached unused code")
    `ASSERT_ALWAYS(a_push_room, !(push && fifo_stat.full), "packet pushed into full queue")

endmodule

[sv/psmt_fifo.sv]
`include "assert_macros.svh"

module psmt_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  psmt_pkg::packet_t    push_pkt,
    input  logic                 pop,
    output psmt_pkg::packet_t    pop_pkt,
    output psmt_pkg::fifo_stat_t stat
);
    import psmt_pkg::*;

    packet_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                     do_push, do_pop;

    assign stat.full  = (cnt_reg == FIFO_CNT_BITS'(FIFO_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_pkt    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_pkt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    `ASSERT_ALWAYS(a_cnt_bound, cnt_reg <= FIFO_CNT_BITS'(FIFO_DEPTH), "queue count overflow")
    `ASSERT_NEXT(a_cnt_inc, do_push && !do_pop, cnt_reg == $past(cnt_reg) + 1'b1, "count lost push")

endmodule

[sv/psmt_back.sv]
`include "assert_macros.svh"

module psmt_back #(
    parameter int COORD_BITS = 12
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [COORD_BITS-1:0]  x_lim,
    input  logic [COORD_BITS-1:0]  y_lim,
    input  psmt_pkg::fifo_stat_t   fifo_stat,
    input  psmt_pkg::packet_t      pop_pkt,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [COORD_BITS-1:0]  pos_x,
    output logic [COORD_BITS-1:0]  pos_y,
    output logic [2:0]             buttons
);
    import psmt_pkg::*;

    localparam int SW = ((COORD_BITS > 10) ? COORD_BITS : 10) + 2;

    logic [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic                  valid_reg, valid_next;
    logic [2:0]            btn_reg;
    logic signed [10:0]    dx, dy;
    logic signed [SW-1:0]  nx, ny;

    function automatic logic [COORD_BITS-1:0] clamp(input logic signed [SW-1:0] v,
                                                   input logic [COORD_BITS-1:0] hi);
        logic signed [SW-1:0] hi_s;
        hi_s = $signed({{(SW-COORD_BITS){1'b0}}, hi});
        if (v < 0)
        begin
            return '0;
        end
        else if (v > hi_s)
        begin
            return hi;
        end
        return v[COORD_BITS-1:0];
    endfunction

    // take a packet when the output register is free or being emptied
    assign pop = !fifo_stat.empty && (!valid_reg || out_ready);

    always_comb
    begin
        dx = axis_delta(pop_pkt.x_byte, pop_pkt.status[4], pop_pkt.status[6]);
        dy = axis_delta(pop_pkt.y_byte, pop_pkt.status[5], pop_pkt.status[7]);
        nx = $signed({{(SW-COORD_BITS){1'b0}}, cur_x_reg}) + SW'(dx);
        // screen y grows downward, mouse y grows upward
        ny = $signed({{(SW-COORD_BITS){1'b0}}, cur_y_reg}) - SW'(dy);
        cur_x_next = pop ? clamp(nx, x_lim) : cur_x_reg;
        cur_y_next = pop ? clamp(ny, y_lim) : cur_y_reg;
        valid_next = pop || (valid_reg && !out_ready);
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            btn_reg <= pop_pkt.status[2:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg <= '0;
            cur_y_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid = valid_reg;
    assign pos_x     = cur_x_reg;
    assign pos_y     = cur_y_reg;
    assign buttons   = btn_reg;

    `ASSERT_NEXT(a_hold_cursor, !pop, cur_x_reg == $past(cur_x_reg), "cursor moved without packet")

endmodule
